// ===== hw/rtl/sync_framed_command_parser_defines.svh =====
// Assertion macros shared by the parser's checker.
`ifndef SYNC_FRAMED_COMMAND_PARSER_DEFINES_SVH
`define SYNC_FRAMED_COMMAND_PARSER_DEFINES_SVH

// Checked out of reset only.
`define SFCP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define SFCP_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/sfcp_pkg.sv =====
// Types and constants of the sync framed command parser.
package sfcp_pkg;

   // result queue between the parser and the output stage
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPW    = 2;
   localparam int unsigned QLW    = 3;

   // configuration port
   localparam int unsigned CSR_IW = 2;
   localparam int unsigned CSR_DW = 8;

   localparam int unsigned CMD_W = 6;

   typedef enum logic [CSR_IW-1:0] {
      CSR_SYNC_FIRST  = 2'd0,
      CSR_SYNC_SECOND = 2'd1,
      CSR_SYNC_THIRD  = 2'd2
   } csr_index_type;

   localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
   localparam logic [7:0] SYNC_THIRD_RST  = 8'hA5;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_WR_OK   = 2'd2,
      KIND_WR_REJ  = 2'd3
   } kind_type;

   typedef enum logic [5:0] {
      PH_SYNC1 = 6'b000001,
      PH_SYNC2 = 6'b000010,
      PH_SYNC3 = 6'b000100,
      PH_IDHI  = 6'b001000,
      PH_IDLO  = 6'b010000,
      PH_DATA  = 6'b100000
   } phase_type;

   typedef enum logic [2:0] {
      CL_NONE   = 3'd0,
      CL_WR_OK  = 3'd1,
      CL_WR_REJ = 3'd2,
      CL_HEADER = 3'd3,
      CL_DATA   = 3'd4
   } class_type;

   typedef struct packed {
      kind_type         kind;
      logic [CMD_W-1:0] command_id;
      logic [7:0]       payload_byte;
      logic [7:0]       byte_index;
      logic             last;
   } rsp_rec_type;

   typedef struct packed {
      logic        valid;
      rsp_rec_type rec;
   } q_push_type;

   typedef struct packed {
      logic [QLW-1:0] level;
      logic           nonempty;
   } q_status_type;

endpackage

// ===== hw/rtl/sfcp_channels.sv =====
// Valid/ready channel interfaces for the parser's request and response items.
interface sfcp_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [7:0]  rx_byte;
   logic [15:0] table_command;
   logic [7:0]  table_length;

   modport source (output valid, output opcode, output rx_byte, output table_command,
                   output table_length, input ready);
   modport sink   (input valid, input opcode, input rx_byte, input table_command,
                   input table_length, output ready);
endinterface

interface sfcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [5:0] command_id;
   logic [7:0] payload_byte;
   logic [7:0] byte_index;
   logic       last;

   modport source (output valid, output kind, output command_id, output payload_byte,
                   output byte_index, output last, input ready);
   modport sink   (input valid, input kind, input command_id, input payload_byte,
                   input byte_index, input last, output ready);
endinterface

// ===== hw/rtl/sfcp_queue.sv =====
// Short result queue between the parser front and the output stage.
module sfcp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  sfcp_pkg::q_push_type       push,
   input  logic                       pop,
   output sfcp_pkg::q_status_type     stat,
   output sfcp_pkg::rsp_rec_type      head
);
   import sfcp_pkg::*;

   rsp_rec_type    slot_ff [QDEPTH];
   logic [QPW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QLW-1:0] level_ff, level_in;
   logic           do_pop;

   assign do_pop    = pop && (level_ff != '0);
   assign wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign level_in  = level_ff + QLW'(push.valid) - QLW'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.rec;
      end
   end

   assign stat.level    = level_ff;
   assign stat.nonempty = (level_ff != '0);
   assign head          = slot_ff[rd_ptr_ff];

endmodule

// ===== hw/rtl/sfcp_front.sv =====
// Parser front: frame tracking, length table and result generation.
module sfcp_front #(
   parameter int unsigned COMMAND_COUNT = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   sfcp_req_if.sink                      req_chan,
   input  logic                          csr_we,
   input  logic [sfcp_pkg::CSR_IW-1:0]   csr_index,
   input  logic [sfcp_pkg::CSR_DW-1:0]   csr_wdata,
   input  sfcp_pkg::q_status_type        q_stat,
   output sfcp_pkg::q_push_type          q_push
);
   import sfcp_pkg::*;

   localparam int unsigned IDXW      = (COMMAND_COUNT > 1) ? $clog2(COMMAND_COUNT) : 1;
   localparam logic [15:0] CMD_LIMIT = 16'(COMMAND_COUNT);

   // sync pattern registers
   logic [7:0] sync_first_ff, sync_second_ff, sync_third_ff;

   // length table
   logic [7:0]               len_mem [COMMAND_COUNT];
   logic [COMMAND_COUNT-1:0] tab_vld_ff;
   logic [7:0]               rd_len_ff;
   logic                     rd_vld_ff;
   logic [IDXW-1:0]          wr_addr, rd_addr;
   logic                     wr_en;

   // accept stage
   phase_type        phase_ff, phase_in, phase_eff;
   logic [7:0]       idhi_ff, idhi_in;
   logic             accept;
   logic [QLW:0]     room_need;
   logic [15:0]      cmd_full;
   logic             cmd_ok, tab_ok;

   // result stage
   logic             b_valid_ff;
   class_type        b_class_ff, b_class_in;
   logic [CMD_W-1:0] b_cmd_ff, b_cmd_in;
   logic [7:0]       b_byte_ff, b_byte_in;
   logic [CMD_W-1:0] cur_cmd_ff, cur_cmd_in;
   logic [7:0]       remain_ff, remain_in;
   logic [7:0]       pos_ff, pos_in;
   logic [7:0]       len_eff;
   logic             b_end;

   // room for the item in the result stage plus the one taken now
   assign room_need      = {1'b0, q_stat.level} + (QLW+1)'(b_valid_ff);
   assign req_chan.ready = (room_need < (QLW+1)'(QDEPTH));
   assign accept         = req_chan.valid && req_chan.ready;

   assign cmd_full = {idhi_ff, req_chan.rx_byte};
   assign cmd_ok   = (cmd_full < CMD_LIMIT);
   assign tab_ok   = (req_chan.table_command < CMD_LIMIT);
   assign wr_en    = accept && req_chan.opcode && tab_ok;
   assign wr_addr  = req_chan.table_command[IDXW-1:0];
   assign rd_addr  = cmd_full[IDXW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RST;
         sync_second_ff <= SYNC_SECOND_RST;
         sync_third_ff  <= SYNC_THIRD_RST;
      end else if (csr_we) begin
         if (csr_index == CSR_SYNC_FIRST) begin
            sync_first_ff <= csr_wdata;
         end
         if (csr_index == CSR_SYNC_SECOND) begin
            sync_second_ff <= csr_wdata;
         end
         if (csr_index == CSR_SYNC_THIRD) begin
            sync_third_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         len_mem[wr_addr] <= req_chan.table_length;
      end
      rd_len_ff <= len_mem[rd_addr];
      rd_vld_ff <= tab_vld_ff[rd_addr];
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         tab_vld_ff <= '0;
      end else if (wr_en) begin
         tab_vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign len_eff = rd_vld_ff ? rd_len_ff : 8'd0;

   // the item in the result stage may close the frame; the next byte then hunts
   assign b_end = b_valid_ff &&
                  (((b_class_ff == CL_HEADER) && (len_eff == 8'd0)) ||
                   ((b_class_ff == CL_DATA) && (remain_ff == 8'd1)));
   assign phase_eff = b_end ? PH_SYNC1 : phase_ff;

   always_comb begin
      phase_in   = phase_eff;
      idhi_in    = idhi_ff;
      b_class_in = CL_NONE;
      b_cmd_in   = b_cmd_ff;
      b_byte_in  = b_byte_ff;
      if (accept) begin
         if (req_chan.opcode) begin
            b_class_in = tab_ok ? CL_WR_OK : CL_WR_REJ;
            b_cmd_in   = req_chan.table_command[CMD_W-1:0];
         end else begin
            case (phase_eff)
               PH_SYNC1: begin
                  phase_in = (req_chan.rx_byte == sync_first_ff) ? PH_SYNC2 : PH_SYNC1;
               end
               PH_SYNC2: begin
                  phase_in = (req_chan.rx_byte == sync_second_ff) ? PH_SYNC3 : PH_SYNC1;
               end
               PH_SYNC3: begin
                  phase_in = (req_chan.rx_byte == sync_third_ff) ? PH_IDHI : PH_SYNC1;
               end
               PH_IDHI: begin
                  idhi_in  = req_chan.rx_byte;
                  phase_in = PH_IDLO;
               end
               PH_IDLO: begin
                  if (cmd_ok) begin
                     b_class_in = CL_HEADER;
                     b_cmd_in   = cmd_full[CMD_W-1:0];
                     phase_in   = PH_DATA;
                  end else begin
                     phase_in = PH_SYNC1;
                  end
               end
               PH_DATA: begin
                  b_class_in = CL_DATA;
                  b_byte_in  = req_chan.rx_byte;
               end
               default: begin
                  phase_in = PH_SYNC1;
               end
            endcase
         end
      end
   end

   always_comb begin
      q_push.valid             = 1'b0;
      q_push.rec.kind          = KIND_PAYLOAD;
      q_push.rec.command_id    = b_cmd_ff;
      q_push.rec.payload_byte  = 8'd0;
      q_push.rec.byte_index    = 8'd0;
      q_push.rec.last          = 1'b1;
      cur_cmd_in               = cur_cmd_ff;
      remain_in                = remain_ff;
      pos_in                   = pos_ff;
      if (b_valid_ff) begin
         case (b_class_ff)
            CL_WR_OK: begin
               q_push.valid    = 1'b1;
               q_push.rec.kind = KIND_WR_OK;
            end
            CL_WR_REJ: begin
               q_push.valid    = 1'b1;
               q_push.rec.kind = KIND_WR_REJ;
            end
            CL_HEADER: begin
               cur_cmd_in = b_cmd_ff;
               remain_in  = len_eff;
               pos_in     = 8'd0;
               if (len_eff == 8'd0) begin
                  q_push.valid    = 1'b1;
                  q_push.rec.kind = KIND_EMPTY;
               end
            end
            CL_DATA: begin
               if (remain_ff != 8'd0) begin
                  q_push.valid            = 1'b1;
                  q_push.rec.kind         = KIND_PAYLOAD;
                  q_push.rec.command_id   = cur_cmd_ff;
                  q_push.rec.payload_byte = b_byte_ff;
                  q_push.rec.byte_index   = pos_ff;
                  q_push.rec.last         = (remain_ff == 8'd1);
                  remain_in               = remain_ff - 8'd1;
                  pos_in                  = pos_ff + 8'd1;
               end
            end
            default: begin
               q_push.valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SYNC1;
         idhi_ff    <= 8'd0;
         b_valid_ff <= 1'b0;
         cur_cmd_ff <= '0;
         remain_ff  <= 8'd0;
         pos_ff     <= 8'd0;
      end else begin
         phase_ff   <= phase_in;
         idhi_ff    <= idhi_in;
         b_valid_ff <= accept;
         cur_cmd_ff <= cur_cmd_in;
         remain_ff  <= remain_in;
         pos_ff     <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      b_class_ff <= b_class_in;
      b_cmd_ff   <= b_cmd_in;
      b_byte_ff  <= b_byte_in;
   end

endmodule

// ===== hw/rtl/sfcp_back.sv =====
// Output stage: drains the result queue into the response channel register.
module sfcp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  sfcp_pkg::q_status_type q_stat,
   input  sfcp_pkg::rsp_rec_type  q_head,
   output logic                   q_pop,
   sfcp_rsp_if.source             rsp_chan
);
   import sfcp_pkg::*;

   logic        out_valid_ff, out_valid_in;
   rsp_rec_type out_rec_ff;

   assign q_pop        = q_stat.nonempty && (!out_valid_ff || rsp_chan.ready);
   assign out_valid_in = q_pop || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_rec_ff <= q_head;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.kind         = out_rec_ff.kind;
   assign rsp_chan.command_id   = out_rec_ff.command_id;
   assign rsp_chan.payload_byte = out_rec_ff.payload_byte;
   assign rsp_chan.byte_index   = out_rec_ff.byte_index;
   assign rsp_chan.last         = out_rec_ff.last;

endmodule

// ===== hw/rtl/sync_framed_command_parser.sv =====
// Path: a result passes the result stage register, the result queue and the output register.
// Throughput: one item per cycle; req_chan.ready falls only when the 4-entry result
//   queue plus the one item in the result stage would be full.
// Reset (synchronous, active high): parser hunts for the first sync byte, sync
//   registers load AA/55/A5 hex, the length table reads all zero at once (one
//   valid flop per entry, no clearing pass), queue and output stage empty.
module sync_framed_command_parser #(
   parameter int unsigned COMMAND_COUNT = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   sfcp_req_if.sink                     req_chan,
   sfcp_rsp_if.source                   rsp_chan,
   input  logic                         csr_we,
   input  logic [sfcp_pkg::CSR_IW-1:0]  csr_index,
   input  logic [sfcp_pkg::CSR_DW-1:0]  csr_wdata
);
   import sfcp_pkg::*;

   // front -> queue -> back; each side stalls on its own
   q_push_type   q_push;
   q_status_type q_stat;
   rsp_rec_type  q_head;
   logic         q_pop;

   // Front: sync hunt, header decode, length table lookup and writes, per-byte results.
   // A frame's end is seen one stage late; the front corrects its phase from
   // the item in flight so back-to-back bytes are never misclassified.
   sfcp_front #(
      .COMMAND_COUNT (COMMAND_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_stat    (q_stat),
      .q_push    (q_push)
   );

   sfcp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .pop   (q_pop),
      .stat  (q_stat),
      .head  (q_head)
   );

   // Back: output register; accepts the next result while the current one is taken.
   sfcp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== hw/rtl/sfcp_checker.sv =====
// Port-level checks of the parser's response channel, bound to the top level.
`include "sync_framed_command_parser_defines.svh"

module sfcp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [5:0] rsp_command_id,
   input logic [7:0] rsp_payload_byte,
   input logic [7:0] rsp_byte_index,
   input logic       rsp_last
);
   import sfcp_pkg::*;

   logic        rsp_stall;
   logic        rsp_side;
   logic        side_clear;
   logic [24:0] rsp_fields;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign rsp_side   = rsp_valid && (rsp_kind != KIND_PAYLOAD);
   assign side_clear = rsp_last && (rsp_payload_byte == 8'd0) && (rsp_byte_index == 8'd0);
   assign rsp_fields = {rsp_kind, rsp_command_id, rsp_payload_byte, rsp_byte_index, rsp_last};

   `SFCP_ASSERT_RST(a_reset_quiet, reset |=> !rsp_valid, "result shown right after reset")

   `SFCP_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_fields), "held result changed")

   `SFCP_ASSERT(a_side_fields, rsp_side |-> side_clear, "non-payload result has stray fields")

endmodule

bind sync_framed_command_parser sfcp_checker u_sfcp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_kind         (rsp_chan.kind),
   .rsp_command_id   (rsp_chan.command_id),
   .rsp_payload_byte (rsp_chan.payload_byte),
   .rsp_byte_index   (rsp_chan.byte_index),
   .rsp_last         (rsp_chan.last)
);

// ===== bench/testbench.sv =====
// Self-checking bench for the sync framed command parser: directed and random byte streams.
`timescale 1ns / 100ps

module testbench;
   import sfcp_pkg::*;

   localparam int unsigned COMMANDS   = 64;
   localparam int unsigned SEG_ITEMS  = 320;   // scored items per random segment
   localparam int unsigned SEGMENTS   = 6;
   localparam int unsigned DRAIN_WAIT = 6;     // cycles waited past the pipeline latency
   localparam int unsigned HOLD_LONG  = 300;   // receiver hold-off for the fill test

   // item opcodes
   localparam logic OP_STREAM   = 1'b0;
   localparam logic OP_TABLE_WR = 1'b1;

   // index past the register list; writes there must change nothing
   localparam logic [CSR_IW-1:0] CSR_UNUSED = 2'd3;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [CSR_IW-1:0]   csr_index;
   logic [CSR_DW-1:0]   csr_wdata;

   sfcp_req_if req_if();
   sfcp_rsp_if rsp_if();

   sync_framed_command_parser #(
      .COMMAND_COUNT(COMMANDS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Parser model: our own copy of the sync registers, the frame state and the
   // length table. Runs on every accepted item, pushes any result it predicts.
   // ---------------------------------------------------------------------------
   logic [7:0]       sync_val [3];
   phase_type        model_phase;
   logic [7:0]       model_id_high;
   logic [CMD_W-1:0] model_cmd;
   logic [7:0]       model_left;     // payload bytes still to come
   logic [7:0]       model_pos;      // index of the next payload byte
   logic [7:0]       len_tbl [COMMANDS];

   rsp_rec_type      pending_rsp [$];

   int unsigned      err_count;
   int unsigned      stim_items;     // items that count toward the random budget
   int unsigned      send_idle_pct;
   int unsigned      recv_idle_pct;
   int               hold_left;

   function automatic void predict_parse(input logic op, input logic [7:0] rx,
                                         input logic [15:0] tcmd, input logic [7:0] tlen);
      rsp_rec_type r;
      logic [15:0] cmd;
      r = '0;
      if (op == OP_TABLE_WR) begin
         // table writes answer at once and never touch the frame state
         r.command_id = tcmd[CMD_W-1:0];
         r.last       = 1'b1;
         if (tcmd < COMMANDS) begin
            len_tbl[tcmd[CMD_W-1:0]] = tlen;
            r.kind = KIND_WR_OK;
         end else begin
            r.kind = KIND_WR_REJ;
         end
         pending_rsp.push_back(r);
         return;
      end
      case (model_phase)
         // a mismatching sync byte is dropped, not retried as a first sync byte
         PH_SYNC1: model_phase = (rx == sync_val[0]) ? PH_SYNC2 : PH_SYNC1;
         PH_SYNC2: model_phase = (rx == sync_val[1]) ? PH_SYNC3 : PH_SYNC1;
         PH_SYNC3: model_phase = (rx == sync_val[2]) ? PH_IDHI : PH_SYNC1;
         PH_IDHI: begin
            model_id_high = rx;
            model_phase   = PH_IDLO;
         end
         PH_IDLO: begin
            cmd = {model_id_high, rx};
            if (cmd >= COMMANDS) begin
               model_phase = PH_SYNC1;            // out of range: frame dropped
            end else begin
               model_cmd  = cmd[CMD_W-1:0];
               model_pos  = '0;
               model_left = len_tbl[cmd[CMD_W-1:0]];   // length latched here
               if (model_left == 0) begin
                  r.kind       = KIND_EMPTY;
                  r.command_id = model_cmd;
                  r.last       = 1'b1;
                  pending_rsp.push_back(r);
                  model_phase = PH_SYNC1;
               end else begin
                  model_phase = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            if (model_left == 0) begin
               model_phase = PH_SYNC1;
            end else begin
               r.kind         = KIND_PAYLOAD;
               r.command_id   = model_cmd;
               r.payload_byte = rx;
               r.byte_index   = model_pos;
               r.last         = (model_left == 1);
               pending_rsp.push_back(r);
               model_left = model_left - 1'b1;
               model_pos  = model_pos + 1'b1;
               if (model_left == 0) model_phase = PH_SYNC1;
            end
         end
         default: model_phase = PH_SYNC1;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      err_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // Monitor: prediction first, then the result check, both on the rising edge.
   always @(posedge clock) begin
      rsp_rec_type want;
      if (reset) begin
         sync_val[0]   = SYNC_FIRST_RST;
         sync_val[1]   = SYNC_SECOND_RST;
         sync_val[2]   = SYNC_THIRD_RST;
         model_phase   = PH_SYNC1;
         model_id_high = '0;
         model_cmd     = '0;
         model_left    = '0;
         model_pos     = '0;
         for (int i = 0; i < COMMANDS; i++) len_tbl[i] = '0;
      end else begin
         if (req_if.valid && req_if.ready)
            predict_parse(req_if.opcode, req_if.rx_byte, req_if.table_command,
                          req_if.table_length);
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected: kind %0d cmd %0d",
                                         rsp_if.kind, rsp_if.command_id));
            end else begin
               want = pending_rsp.pop_front();
               check_field("kind", 8'(rsp_if.kind), 8'(want.kind));
               check_field("command_id", 8'(rsp_if.command_id), 8'(want.command_id));
               check_field("payload_byte", rsp_if.payload_byte, want.payload_byte);
               check_field("byte_index", rsp_if.byte_index, want.byte_index);
               check_field("last", 8'(rsp_if.last), 8'(want.last));
            end
         end
      end
   end

   // Receiver: random stalls, plus a counted hold-off the fill test arms.
   always @(negedge clock) begin
      if (hold_left > 0) hold_left = hold_left - 1;
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------------------
   // Sender side. Every task here starts and ends on a falling edge.
   // ---------------------------------------------------------------------------
   task automatic send_item(input logic op, input logic [7:0] rx,
                            input logic [15:0] tcmd, input logic [7:0] tlen);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_if.valid         = 1'b1;
      req_if.opcode        = op;
      req_if.rx_byte       = rx;
      req_if.table_command = tcmd;
      req_if.table_length  = tlen;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   // unused fields carry junk so the block must ignore them
   task automatic send_stream(input logic [7:0] rx);
      send_item(OP_STREAM, rx, 16'($urandom), 8'($urandom));
      stim_items++;
   endtask

   task automatic send_table_write(input logic [15:0] cmd, input logic [7:0] len);
      send_item(OP_TABLE_WR, 8'($urandom), cmd, len);
      stim_items++;
   endtask

   task automatic send_header(input logic [7:0] s0, input logic [7:0] s1,
                              input logic [7:0] s2, input logic [15:0] cmd);
      send_stream(s0);
      send_stream(s1);
      send_stream(s2);
      send_stream(cmd[15:8]);
      send_stream(cmd[7:0]);
   endtask

   // wait out every expected result, then the pipeline latency
   task automatic wait_idle();
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [7:0] val);
      csr_index = idx;
      csr_wdata = val;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx <= CSR_SYNC_THIRD) sync_val[idx] = val;
   endtask

   task automatic set_sync(input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] s2);
      write_reg(CSR_SYNC_FIRST, s0);
      write_reg(CSR_SYNC_SECOND, s1);
      write_reg(CSR_SYNC_THIRD, s2);
   endtask

   function automatic logic [15:0] pick_table_cmd();
      return ($urandom_range(99) < 85) ? 16'($urandom_range(COMMANDS - 1)) : 16'($urandom);
   endfunction

   // mostly short payloads; now and then the full byte range
   function automatic logic [7:0] pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 55) return 8'($urandom_range(4));
      if (r < 95) return 8'($urandom_range(20, 5));
      return 8'($urandom);
   endfunction

   // Well-formed frame with random content; sometimes a bad sync byte or a
   // command id out of range, sometimes table writes inside the payload.
   task automatic random_frame();
      logic [7:0]  hdr [5];
      int unsigned n;
      hdr[0] = sync_val[0];
      hdr[1] = sync_val[1];
      hdr[2] = sync_val[2];
      if ($urandom_range(99) < 8) hdr[$urandom_range(2)] = 8'($urandom);
      hdr[3] = ($urandom_range(99) < 90) ? 8'h00 : 8'($urandom);
      hdr[4] = ($urandom_range(99) < 85) ? 8'($urandom_range(COMMANDS - 1)) : 8'($urandom);
      for (int k = 0; k < 5; k++) send_stream(hdr[k]);
      if (model_phase == PH_DATA) begin
         n = model_left;
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 4) send_table_write(pick_table_cmd(), pick_length());
            send_stream(8'($urandom));
         end
      end
   endtask

   task automatic run_random_traffic(input int unsigned target);
      int unsigned r;
      while (stim_items < target) begin
         r = $urandom_range(99);
         if (r < 70) begin
            random_frame();
         end else if (r < 85) begin
            repeat ($urandom_range(3, 1)) send_table_write(pick_table_cmd(), pick_length());
         end else begin
            // line noise: not scored against the budget
            repeat ($urandom_range(4, 1))
               send_item(OP_STREAM, 8'($urandom), 16'($urandom), 8'($urandom));
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // reset sync values accepted; cleared table gives an empty command
   task automatic test_reset_state();
      send_header(8'hAA, 8'h55, 8'hA5, 16'd63);
   endtask

   // in-range writes acknowledged, ids at or past the table size rejected
   task automatic test_table_writes();
      send_table_write(16'd0, 8'd2);
      send_table_write(16'd63, 8'd1);
      send_table_write(16'd1, 8'hFF);
      send_table_write(16'd64, 8'hFF);
      send_table_write(16'hFFFF, 8'h00);
   endtask

   // two payload bytes; a table write for the running command lands between
   // them and must not cut the frame short
   task automatic test_payload_frame();
      send_header(8'hAA, 8'h55, 8'hA5, 16'd0);
      send_stream(8'h00);
      send_table_write(16'd0, 8'd0);
      send_stream(8'hFF);
   endtask

   // sync mismatch drops the byte without rechecking it; id 64 drops the frame
   task automatic test_broken_headers();
      send_stream(8'hAA);
      send_stream(8'hAA);
      send_stream(8'h55);
      send_stream(8'hA5);
      send_header(8'hAA, 8'h55, 8'hA5, 16'd64);
   endtask

   // extreme sync values, a write to the unused index, and a register change
   // between the first and second sync byte of a frame
   task automatic test_sync_registers();
      wait_idle();
      set_sync(8'h00, 8'hFF, 8'h00);
      write_reg(CSR_UNUSED, 8'h5A);
      send_stream(8'h00);
      wait_idle();
      write_reg(CSR_SYNC_SECOND, 8'h00);
      send_stream(8'h00);
      send_stream(8'h00);
      send_stream(8'h00);
      send_stream(8'h00);     // command 0, now zero length: empty command
   endtask

   // receiver holds off long enough for the block to fill and stall its input,
   // then the sender pauses until every result is back
   task automatic test_backpressure();
      int unsigned saved_idle;
      saved_idle    = send_idle_pct;
      send_idle_pct = 0;
      @(posedge clock);
      hold_left = HOLD_LONG;
      @(negedge clock);
      repeat (40) send_table_write(pick_table_cmd(), pick_length());
      while (pending_rsp.size() != 0) @(negedge clock);
      send_idle_pct = saved_idle;
   endtask

   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_if.valid         = 1'b0;
      req_if.opcode        = OP_STREAM;
      req_if.rx_byte       = '0;
      req_if.table_command = '0;
      req_if.table_length  = '0;
      rsp_if.ready         = 1'b0;
      err_count            = 0;
      stim_items           = 0;
      hold_left            = 0;
      send_idle_pct        = 37;
      recv_idle_pct        = 54;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_table_writes();
      test_payload_frame();
      test_broken_headers();
      test_sync_registers();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         // two segments per idle pattern: 37/54, then 54/37, then none
         send_idle_pct = (seg < 2) ? 37 : (seg < 4) ? 54 : 0;
         recv_idle_pct = (seg < 2) ? 54 : (seg < 4) ? 37 : 0;
         wait_idle();
         case (seg)
            0: set_sync(8'h00, 8'hFF, 8'h00);
            1: set_sync(8'hFF, 8'h00, 8'hFF);
            2: set_sync(8'hFF, 8'hFF, 8'hFF);
            3: set_sync(8'h00, 8'h00, 8'h00);
            default: set_sync(8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         run_random_traffic((seg + 1) * SEG_ITEMS);
         if (seg == 1) test_backpressure();
      end

      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_rsp.size() != 0) report_mismatch("expected results never arrived");
      if (err_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sfcp_pkg.sv
hw/rtl/sfcp_channels.sv
hw/rtl/sfcp_queue.sv
hw/rtl/sfcp_front.sv
hw/rtl/sfcp_back.sv
hw/rtl/sync_framed_command_parser.sv
hw/rtl/sfcp_checker.sv
bench/testbench.sv
